// ===== rtl/idll_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed doubly linked list: shared package
// Pool size, link format, operation codes and controller states.
// ----------------------------------------------------------------------------
package idll_pkg;

	localparam int NODES  = 256;
	localparam int IDX_W  = $clog2(NODES);
	localparam int SLOT_W = 8;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic valid;
		idx_t idx;
	} link_t;

	localparam int    LINK_W    = $bits(link_t);
	localparam idx_t  LAST_IDX  = IDX_W'(NODES - 1);
	localparam link_t LINK_NULL = '{valid: 1'b0, idx: '0};

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_WB1,
		ST_WB2
	} state_t;

	function automatic link_t mk_link(input idx_t i);
		link_t l;
		l.valid = 1'b1;
		l.idx   = i;
		return l;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/idll_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one list operation and its slot number.
// ----------------------------------------------------------------------------
interface idll_req_if import idll_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              operation;
	logic [SLOT_W-1:0] node_index;

	modport source(output valid, operation, node_index, input ready);
	modport sink(input valid, operation, node_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/idll_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the outcome of one list operation.
// ----------------------------------------------------------------------------
interface idll_rsp_if import idll_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] result_slot;
	logic              pool_full;
	logic [SLOT_W-1:0] head_slot;
	logic              head_valid;
	logic [SLOT_W-1:0] tail_slot;
	logic              tail_valid;
	logic              free_valid;

	modport source(output valid, result_slot, pool_full, head_slot, head_valid,
		tail_slot, tail_valid, free_valid, input ready);
	modport sink(input valid, result_slot, pool_full, head_slot, head_valid,
		tail_slot, tail_valid, free_valid, output ready);
endinterface
`default_nettype wire

// ===== rtl/idll_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module idll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/indexed_doubly_linked_list_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed doubly linked list
// A pool of node slots with next and prev links held in two RAMs, a free
// list, and head and tail pointers in registers.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  req      in         operation, node_index
//  rsp      out        result_slot, pool_full, head_slot, head_valid,
//                      tail_slot, tail_valid, free_valid
//
// The link RAMs are read as each request is taken, and the two write-back
// states that follow, WB1 and WB2, update the node and its neighbours.
// After reset a sweep writes the initial links, one slot a cycle, to every slot
// before the first request is taken.
// A pending response does not stop a new request being taken; only the second
// write-back cycle waits while the response register is still full.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list_top import idll_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	idll_req_if.sink   req,
	idll_rsp_if.source rsp
);

	state_t state_q, state_d;
	idx_t   cnt_q;

	link_t free_q, head_q, tail_q, old_q;
	logic  clr_prev_q;

	op_t               op_s1;
	logic              go_s1;
	idx_t              idx_s1;
	idx_t              pos_s1;
	logic [SLOT_W-1:0] raw_s1;

	logic              out_valid_q;
	logic [SLOT_W-1:0] result_slot_q, head_slot_q, tail_slot_q;
	logic              pool_full_q, head_valid_q, tail_valid_q, free_valid_q;

	logic  nxt_we, prv_we;
	idx_t  nxt_waddr, prv_waddr, raddr;
	link_t nxt_wdata, prv_wdata, nxt_rdata, prv_rdata;

	logic accept, adv, is_head, is_tail, idx_ok;
	idx_t req_idx;

	assign accept  = req.valid && req.ready;
	assign adv     = !out_valid_q || rsp.ready;
	assign req_idx = IDX_W'(req.node_index);
	assign idx_ok  = 32'(req.node_index) < NODES;
	assign is_head = head_q.valid && (head_q.idx == idx_s1);
	assign is_tail = tail_q.valid && (tail_q.idx == idx_s1);

	idll_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_next_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.raddr (raddr),
		.rdata (nxt_rdata)
	);

	idll_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_prev_ram (
		.clk   (clk),
		.we    (prv_we),
		.waddr (prv_waddr),
		.wdata (prv_wdata),
		.raddr (raddr),
		.rdata (prv_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (cnt_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_WB1;
				end
			end
			ST_WB1: begin
				state_d = ST_WB2;
			end
			ST_WB2: begin
				if (adv) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		nxt_we    = 1'b0;
		nxt_waddr = idx_s1;
		nxt_wdata = LINK_NULL;
		prv_we    = 1'b0;
		prv_waddr = idx_s1;
		prv_wdata = LINK_NULL;
		raddr     = (op_t'(req.operation) == OP_DELETE) ? req_idx : free_q.idx;
		req.ready = 1'b0;
		case (state_q)
			ST_INIT: begin
				nxt_we    = 1'b1;
				nxt_waddr = cnt_q;
				nxt_wdata = (cnt_q == LAST_IDX) ? LINK_NULL : mk_link(cnt_q + 1'b1);
				prv_we    = 1'b1;
				prv_waddr = cnt_q;
			end
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_WB1: begin
				if (go_s1) begin
					if (op_s1 == OP_INSERT) begin
						nxt_we    = 1'b1;
						nxt_waddr = pos_s1;
						nxt_wdata = head_q;
						prv_we    = 1'b1;
						prv_waddr = pos_s1;
					end else if (is_head) begin
						prv_we    = nxt_rdata.valid;
						prv_waddr = nxt_rdata.idx;
					end else if (prv_rdata.valid) begin
						nxt_we    = 1'b1;
						nxt_waddr = prv_rdata.idx;
						nxt_wdata = nxt_rdata;
						prv_we    = nxt_rdata.valid;
						prv_waddr = nxt_rdata.idx;
						prv_wdata = prv_rdata;
					end
				end
			end
			ST_WB2: begin
				if (adv && go_s1) begin
					if (op_s1 == OP_INSERT) begin
						prv_we    = old_q.valid;
						prv_waddr = old_q.idx;
						prv_wdata = mk_link(pos_s1);
					end else begin
						nxt_we    = 1'b1;
						nxt_wdata = free_q;
						prv_we    = clr_prev_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			free_q      <= mk_link('0);
			head_q      <= LINK_NULL;
			tail_q      <= LINK_NULL;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == ST_WB1 && go_s1) begin
				if (op_s1 == OP_INSERT) begin
					free_q <= nxt_rdata;
					head_q <= mk_link(pos_s1);
					if (!tail_q.valid) begin
						tail_q <= mk_link(pos_s1);
					end
				end else begin
					if (is_tail) begin
						tail_q <= prv_rdata;
					end
					if (is_head) begin
						head_q <= nxt_rdata;
					end
				end
			end
			if (state_q == ST_WB2 && adv) begin
				out_valid_q <= 1'b1;
				if (go_s1 && op_s1 == OP_DELETE) begin
					free_q <= mk_link(idx_s1);
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op_t'(req.operation);
			idx_s1 <= req_idx;
			raw_s1 <= req.node_index;
			pos_s1 <= free_q.idx;
			go_s1  <= (op_t'(req.operation) == OP_DELETE) ? idx_ok : free_q.valid;
		end
		if (state_q == ST_WB1) begin
			old_q      <= head_q;
			clr_prev_q <= !is_head && prv_rdata.valid;
		end
		if (state_q == ST_WB2 && adv) begin
			if (op_s1 == OP_INSERT) begin
				result_slot_q <= go_s1 ? SLOT_W'(pos_s1) : '0;
				pool_full_q   <= !go_s1;
				free_valid_q  <= free_q.valid;
			end else begin
				result_slot_q <= raw_s1;
				pool_full_q   <= 1'b0;
				free_valid_q  <= go_s1 || free_q.valid;
			end
			head_slot_q  <= head_q.valid ? SLOT_W'(head_q.idx) : '0;
			head_valid_q <= head_q.valid;
			tail_slot_q  <= tail_q.valid ? SLOT_W'(tail_q.idx) : '0;
			tail_valid_q <= tail_q.valid;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_slot = result_slot_q;
	assign rsp.pool_full   = pool_full_q;
	assign rsp.head_slot   = head_slot_q;
	assign rsp.head_valid  = head_valid_q;
	assign rsp.tail_slot   = tail_slot_q;
	assign rsp.tail_valid  = tail_valid_q;
	assign rsp.free_valid  = free_valid_q;

	a_accept_to_wb1 : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_WB1)
		else $error("An accepted request did not enter the first write-back cycle.");

	a_idle_no_write : assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !nxt_we && !prv_we)
		else $error("A link RAM was written while the controller was idle.");

	a_rsp_from_wb2 : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_WB2))
		else $error("A response appeared without a second write-back cycle.");

	a_free_changes : assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(free_q) |-> $past(state_q == ST_WB1 || state_q == ST_WB2))
		else $error("The free-list head changed outside the write-back cycles.");

endmodule
`default_nettype wire
